>>> hdl/emission_absorption_ray_march_core_assert.svh
// ----------------------------------------------------------------------------
// Emission-absorption ray march core assertion macros
// Concurrent check shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef EMISSION_ABSORPTION_RAY_MARCH_CORE_ASSERT_SVH
`define EMISSION_ABSORPTION_RAY_MARCH_CORE_ASSERT_SVH

// same-cycle implication
`define EARM_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("earm: same-cycle check failed");

// next-cycle implication
`define EARM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("earm: next-cycle check failed");

`endif

>>> hdl/earm_pkg.sv
// ----------------------------------------------------------------------------
// Emission-absorption ray march package
// Widths, fixed-point constants, register indexes, sequencer states and the
// exp(-t) lookup table shared by the core.
// ----------------------------------------------------------------------------
package earm_pkg;

   // field widths
   localparam int DATA_W     = 32;
   localparam int TRANS_W    = 17;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int FIXED_FRAC = 16;

   // channels
   localparam int CHANNELS = 3;
   localparam int CH_W     = $clog2(CHANNELS);
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_LENGTH         = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DENSITY_GAIN        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSPARENCY_OFFSET = 2'd2;

   // Q1.16 one and related constants
   localparam int ONE_INT = 65536;
   localparam logic [TRANS_W-1:0] ONE_Q16 = TRANS_W'(ONE_INT);
   localparam logic [DATA_W-1:0]  SUM_MAX = '1;
   localparam logic [DATA_W-1:0]  STEP_RESET = DATA_W'(ONE_INT);
   localparam logic [DATA_W-1:0]  GAIN_RESET = DATA_W'(ONE_INT);

   // transmittance plus offset, signed, two guard bits
   localparam int TR_W = DATA_W + 2;
   localparam logic signed [TR_W-1:0] TR_ONE   = TR_W'(ONE_INT);
   localparam logic signed [TR_W-1:0] TR_FLOOR = TR_W'(1);

   // exponential table
   localparam int EXP_TABLE_ENTRIES = 256;
   localparam int FRACTION_BITS     = 16;
   localparam int IDX_W             = $clog2(EXP_TABLE_ENTRIES);
   localparam int FRAC_IDX_W        = FRACTION_BITS + IDX_W;
   localparam logic [FRAC_IDX_W-1:0] ENTRIES_WIDE = FRAC_IDX_W'(EXP_TABLE_ENTRIES);
   localparam logic [DATA_W-1:0] LOG2E_Q30 = 32'd1549082005;
   localparam logic [63:0]       LN2_Q32   = 64'd2977044472;
   localparam int SERIES_TERMS = 14;
   localparam int LOG2E_FRAC   = 30;
   localparam int X_SHIFT      = LOG2E_FRAC + FIXED_FRAC - FRACTION_BITS;

   // optical depth is exhausted at 16.0 (2^4)
   localparam int EXP_RANGE_BITS = 4;
   localparam int A_W            = FIXED_FRAC + EXP_RANGE_BITS;
   localparam int FAR_BIT        = FIXED_FRAC + A_W;
   localparam int WHOLE_W        = 5;
   localparam logic [WHOLE_W-1:0] WHOLE_LIMIT = 5'd16;

   typedef logic [TRANS_W-1:0] exp_table_type [EXP_TABLE_ENTRIES];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ABS,
      ST_LOG,
      ST_EXP,
      ST_MIX,
      ST_ACC,
      ST_TRN,
      ST_GAIN,
      ST_GSAT,
      ST_DONE
   } march_state_type;

   // exp(-t) for t = k*ln2/entries, alternating series in Q0.32
   function automatic exp_table_type build_exp_table();
      exp_table_type tab;
      logic [63:0] t;
      logic [63:0] sum;
      logic [63:0] term;
      for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
         t    = (64'(k) * LN2_Q32) / EXP_TABLE_ENTRIES;
         sum  = 64'd1 << 32;
         term = 64'd1 << 32;
         for (int n = 1; n <= SERIES_TERMS; n++) begin
            term = ((term * t) >> 32) / 64'(n);
            if ((n & 1) != 0) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         sum    = (sum + 64'd32768) >> 16;
         tab[k] = sum[TRANS_W-1:0];
      end
      return tab;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

endpackage

>>> hdl/emission_absorption_ray_march_core.sv
// ----------------------------------------------------------------------------
// Emission-absorption ray march core
// Front-to-back compositing of one RGB ray, one march sample per item, on a
// single shared 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   direction   handshake               contents
//  req_*     in          req_valid / req_ready   absorb and emit per RGB, last flag
//  rsp_*     out         rsp_valid / rsp_ready   color and trans per RGB, trans_valid
//  csr_*     in          csr_write_enable        step, gain, offset (index 0..2)
//
//  Sequence: after acceptance each channel in turn runs ABS, LOG, EXP, MIX, ACC
//  and TRN on the shared multiplier (depth, log2 scale, exp lookup with emit*T,
//  mix, accumulate, T update); req_ready returns once back in idle. The last
//  sample adds gain multiplies (GAIN, GSAT) and DONE to load the result register.
//  Reset: synchronous; T returns to one, sums to zero, registers to defaults.
//  Stalls: a pending result does not block accepting samples; only a finished
//  ray waits in its final cycle until the result register is free.
// ----------------------------------------------------------------------------
module emission_absorption_ray_march_core (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_absorb_red,
   input  logic signed [31:0]  req_absorb_green,
   input  logic signed [31:0]  req_absorb_blue,
   input  logic signed [31:0]  req_emit_red,
   input  logic signed [31:0]  req_emit_green,
   input  logic signed [31:0]  req_emit_blue,
   input  logic                req_last_sample,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_color_red,
   output logic [31:0]         rsp_color_green,
   output logic [31:0]         rsp_color_blue,
   output logic [16:0]         rsp_trans_red,
   output logic [16:0]         rsp_trans_green,
   output logic [16:0]         rsp_trans_blue,
   output logic                rsp_trans_valid,

   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_write_data
);

   // sequencer
   earm_pkg::march_state_type state_ff, state_in;
   logic [earm_pkg::CH_W-1:0] ch_ff, ch_in;

   // configuration
   logic [earm_pkg::DATA_W-1:0] step_ff;
   logic [earm_pkg::DATA_W-1:0] gain_ff;
   logic [earm_pkg::DATA_W-1:0] offset_ff;

   // ray state
   logic [earm_pkg::TRANS_W-1:0] trans_ff [earm_pkg::CHANNELS];
   logic [earm_pkg::DATA_W-1:0]  sum_ff   [earm_pkg::CHANNELS];

   // captured sample
   logic [earm_pkg::DATA_W-1:0] absorb_ff [earm_pkg::CHANNELS];
   logic [earm_pkg::DATA_W-1:0] emit_ff   [earm_pkg::CHANNELS];
   logic                        last_ff;

   // shared multiplier and intermediates
   logic [earm_pkg::DATA_W-1:0]  mul_a, mul_b;
   logic [earm_pkg::PROD_W-1:0]  prod_ff;
   logic                         far_ff;
   logic [earm_pkg::TRANS_W-1:0] e_ff;
   logic [earm_pkg::DATA_W-1:0]  color_ff [earm_pkg::CHANNELS];

   // result register
   logic                         rsp_valid_ff;
   logic [earm_pkg::DATA_W-1:0]  rsp_color_ff [earm_pkg::CHANNELS];
   logic [earm_pkg::TRANS_W-1:0] rsp_trans_ff [earm_pkg::CHANNELS];
   logic                         rsp_tvalid_ff;

   // datapath terms
   logic [earm_pkg::DATA_W-1:0]     sigma_cur, emit_cur, sigma_pos, emit_pos;
   logic [earm_pkg::TRANS_W-1:0]    t_cur;
   logic [earm_pkg::DATA_W-1:0]     sum_cur;
   logic [earm_pkg::A_W-1:0]        a_q;
   logic                            far_in;
   logic [earm_pkg::PROD_W-1:0]     x_full;
   logic [earm_pkg::WHOLE_W-1:0]    whole;
   logic [earm_pkg::FRACTION_BITS-1:0] frac;
   logic [earm_pkg::FRAC_IDX_W-1:0] scaled;
   logic [earm_pkg::IDX_W-1:0]      idx;
   logic [earm_pkg::TRANS_W-1:0]    tab_val, e_in;
   logic [earm_pkg::DATA_W-1:0]     scaled_q;
   logic [earm_pkg::TRANS_W-1:0]    one_minus_e;
   logic [earm_pkg::DATA_W:0]       sum_wide;
   logic [earm_pkg::DATA_W-1:0]     sum_sat;
   logic [earm_pkg::TRANS_W-1:0]    t_new;
   logic [earm_pkg::DATA_W-1:0]     color_sat;
   logic                            slot_free;
   logic                            any_dim;
   logic signed [earm_pkg::TR_W-1:0] tr_sum [earm_pkg::CHANNELS];
   logic [earm_pkg::TRANS_W-1:0]    tr_out [earm_pkg::CHANNELS];

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------
   // per-channel datapath
   // ---------------------------------------------------------------------
   assign sigma_cur = absorb_ff[ch_ff];
   assign emit_cur  = emit_ff[ch_ff];
   assign t_cur     = trans_ff[ch_ff];
   assign sum_cur   = sum_ff[ch_ff];

   // max(v, 0)
   assign sigma_pos = sigma_cur[earm_pkg::DATA_W-1] ? '0 : sigma_cur;
   assign emit_pos  = emit_cur[earm_pkg::DATA_W-1]  ? '0 : emit_cur;

   // optical depth a = sigma*step >> 16; only its low bits matter below 16.0
   assign a_q    = prod_ff[earm_pkg::FAR_BIT-1:earm_pkg::FIXED_FRAC];
   assign far_in = |prod_ff[earm_pkg::PROD_W-1:earm_pkg::FAR_BIT];

   // x = a*log2e, whole part picks the shift, fraction the table row
   assign x_full = prod_ff >> earm_pkg::X_SHIFT;
   assign whole  = x_full[earm_pkg::FRACTION_BITS +: earm_pkg::WHOLE_W];
   assign frac   = x_full[earm_pkg::FRACTION_BITS-1:0];
   assign scaled = {{earm_pkg::IDX_W{1'b0}}, frac} * earm_pkg::ENTRIES_WIDE;
   assign idx    = scaled[earm_pkg::FRAC_IDX_W-1:earm_pkg::FRACTION_BITS];
   assign tab_val = earm_pkg::EXP_TABLE[idx];
   assign e_in   = (far_ff || (whole > earm_pkg::WHOLE_LIMIT)) ? '0 : (tab_val >> whole);

   // Q16.16 truncation of the product
   assign scaled_q    = prod_ff[earm_pkg::FIXED_FRAC +: earm_pkg::DATA_W];
   assign one_minus_e = earm_pkg::ONE_Q16 - e_ff;

   // saturating radiance accumulate; non-positive emission adds zero
   assign sum_wide = {1'b0, sum_cur} + {1'b0, scaled_q};
   assign sum_sat  = sum_wide[earm_pkg::DATA_W] ? earm_pkg::SUM_MAX
                                                : sum_wide[earm_pkg::DATA_W-1:0];

   assign t_new = prod_ff[earm_pkg::FIXED_FRAC +: earm_pkg::TRANS_W];

   // sum*gain >> 16, saturated
   assign color_sat = (|prod_ff[earm_pkg::PROD_W-1:earm_pkg::FIXED_FRAC+earm_pkg::DATA_W])
                      ? earm_pkg::SUM_MAX : scaled_q;

   // final transmittance: T + offset clamped to [1 LSB, one]; one if no channel dimmed
   always_comb begin
      any_dim = 1'b0;
      for (int i = 0; i < earm_pkg::CHANNELS; i++) begin
         if (trans_ff[i] != earm_pkg::ONE_Q16) begin
            any_dim = 1'b1;
         end
      end
      for (int i = 0; i < earm_pkg::CHANNELS; i++) begin
         tr_sum[i] = $signed({{(earm_pkg::TR_W-earm_pkg::TRANS_W){1'b0}}, trans_ff[i]})
                   + $signed({{2{offset_ff[earm_pkg::DATA_W-1]}}, offset_ff});
         if (!any_dim) begin
            tr_out[i] = earm_pkg::ONE_Q16;
         end else if (tr_sum[i] < earm_pkg::TR_FLOOR) begin
            tr_out[i] = earm_pkg::TRANS_W'(1);
         end else if (tr_sum[i] > earm_pkg::TR_ONE) begin
            tr_out[i] = earm_pkg::ONE_Q16;
         end else begin
            tr_out[i] = tr_sum[i][earm_pkg::TRANS_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      case (state_ff)
         earm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = earm_pkg::ST_ABS;
               ch_in    = '0;
            end
         end
         earm_pkg::ST_ABS: state_in = earm_pkg::ST_LOG;
         earm_pkg::ST_LOG: state_in = earm_pkg::ST_EXP;
         earm_pkg::ST_EXP: state_in = earm_pkg::ST_MIX;
         earm_pkg::ST_MIX: state_in = earm_pkg::ST_ACC;
         earm_pkg::ST_ACC: state_in = earm_pkg::ST_TRN;
         earm_pkg::ST_TRN: begin
            if (ch_ff == earm_pkg::LAST_CH) begin
               ch_in    = '0;
               state_in = last_ff ? earm_pkg::ST_GAIN : earm_pkg::ST_IDLE;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = earm_pkg::ST_ABS;
            end
         end
         earm_pkg::ST_GAIN: state_in = earm_pkg::ST_GSAT;
         earm_pkg::ST_GSAT: begin
            if (ch_ff == earm_pkg::LAST_CH) begin
               ch_in    = '0;
               state_in = earm_pkg::ST_DONE;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = earm_pkg::ST_GAIN;
            end
         end
         earm_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = earm_pkg::ST_IDLE;
            end
         end
         default: state_in = earm_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer: outputs (multiplier operands, ready)
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         earm_pkg::ST_IDLE: req_ready = 1'b1;
         earm_pkg::ST_ABS: begin
            mul_a = sigma_pos;
            mul_b = step_ff;
         end
         earm_pkg::ST_LOG: begin
            mul_a = {{(earm_pkg::DATA_W-earm_pkg::A_W){1'b0}}, a_q};
            mul_b = earm_pkg::LOG2E_Q30;
         end
         earm_pkg::ST_EXP: begin
            // emit*T does not wait for e
            mul_a = emit_pos;
            mul_b = {{(earm_pkg::DATA_W-earm_pkg::TRANS_W){1'b0}}, t_cur};
         end
         earm_pkg::ST_MIX: begin
            mul_a = scaled_q;
            mul_b = {{(earm_pkg::DATA_W-earm_pkg::TRANS_W){1'b0}}, one_minus_e};
         end
         earm_pkg::ST_ACC: begin
            mul_a = {{(earm_pkg::DATA_W-earm_pkg::TRANS_W){1'b0}}, t_cur};
            mul_b = {{(earm_pkg::DATA_W-earm_pkg::TRANS_W){1'b0}}, e_ff};
         end
         earm_pkg::ST_GAIN: begin
            mul_a = sum_cur;
            mul_b = gain_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // control and ray state registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= earm_pkg::ST_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= earm_pkg::STEP_RESET;
         gain_ff      <= earm_pkg::GAIN_RESET;
         offset_ff    <= '0;
         for (int i = 0; i < earm_pkg::CHANNELS; i++) begin
            trans_ff[i] <= earm_pkg::ONE_Q16;
            sum_ff[i]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;

         if (csr_write_enable) begin
            case (csr_index)
               earm_pkg::CSR_STEP_LENGTH:         step_ff   <= csr_write_data;
               earm_pkg::CSR_DENSITY_GAIN:        gain_ff   <= csr_write_data;
               earm_pkg::CSR_TRANSPARENCY_OFFSET: offset_ff <= csr_write_data;
               default: ;
            endcase
         end

         if (state_ff == earm_pkg::ST_ACC) begin
            sum_ff[ch_ff] <= sum_sat;
         end
         if (state_ff == earm_pkg::ST_TRN) begin
            trans_ff[ch_ff] <= t_new;
         end

         // end of ray: publish and restart; otherwise clear once taken
         if (state_ff == earm_pkg::ST_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
            for (int i = 0; i < earm_pkg::CHANNELS; i++) begin
               trans_ff[i] <= earm_pkg::ONE_Q16;
               sum_ff[i]   <= '0;
            end
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // payload registers (no reset)
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;

      if (req_valid && req_ready) begin
         absorb_ff[0] <= req_absorb_red;
         absorb_ff[1] <= req_absorb_green;
         absorb_ff[2] <= req_absorb_blue;
         emit_ff[0]   <= req_emit_red;
         emit_ff[1]   <= req_emit_green;
         emit_ff[2]   <= req_emit_blue;
         last_ff      <= req_last_sample;
      end

      if (state_ff == earm_pkg::ST_LOG) begin
         far_ff <= far_in;
      end
      if (state_ff == earm_pkg::ST_EXP) begin
         e_ff <= e_in;
      end
      if (state_ff == earm_pkg::ST_GSAT) begin
         color_ff[ch_ff] <= color_sat;
      end

      if (state_ff == earm_pkg::ST_DONE && slot_free) begin
         for (int i = 0; i < earm_pkg::CHANNELS; i++) begin
            rsp_color_ff[i] <= color_ff[i];
            rsp_trans_ff[i] <= tr_out[i];
         end
         rsp_tvalid_ff <= any_dim;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_red   = rsp_color_ff[0];
   assign rsp_color_green = rsp_color_ff[1];
   assign rsp_color_blue  = rsp_color_ff[2];
   assign rsp_trans_red   = rsp_trans_ff[0];
   assign rsp_trans_green = rsp_trans_ff[1];
   assign rsp_trans_blue  = rsp_trans_ff[2];
   assign rsp_trans_valid = rsp_tvalid_ff;

endmodule

>>> hdl/emission_absorption_ray_march_core_checker.sv
// ----------------------------------------------------------------------------
// Emission-absorption ray march core checker
// Port-level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
`include "emission_absorption_ray_march_core_assert.svh"

module emission_absorption_ray_march_core_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [31:0]         rsp_color_red,
   input logic [31:0]         rsp_color_green,
   input logic [31:0]         rsp_color_blue,
   input logic [16:0]         rsp_trans_red,
   input logic [16:0]         rsp_trans_green,
   input logic [16:0]         rsp_trans_blue,
   input logic                rsp_trans_valid
);

   logic [95:0] color_bus;
   logic [51:0] trans_bus;
   logic        trans_in_range;
   logic        trans_all_one;

   assign color_bus = {rsp_color_red, rsp_color_green, rsp_color_blue};
   assign trans_bus = {rsp_trans_red, rsp_trans_green, rsp_trans_blue, rsp_trans_valid};

   assign trans_in_range = rsp_trans_red != 17'd0 && rsp_trans_red <= 17'd65536
                        && rsp_trans_green != 17'd0 && rsp_trans_green <= 17'd65536
                        && rsp_trans_blue != 17'd0 && rsp_trans_blue <= 17'd65536;
   assign trans_all_one  = rsp_trans_red == 17'd65536 && rsp_trans_green == 17'd65536
                        && rsp_trans_blue == 17'd65536;

   // one sample at a time: ready drops after an item is taken
   `EARM_ASSERT_NEXT(a_ready_drops, clock, reset, req_valid && req_ready, !req_ready)

   // stalled result holds
   `EARM_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(color_bus) && $stable(trans_bus))

   // transmittance floor and ceiling
   `EARM_ASSERT_IMPLY(a_trans_range, clock, reset, rsp_valid, trans_in_range)

   // untouched ray reports fully transparent
   `EARM_ASSERT_IMPLY(a_untouched_clear, clock, reset, rsp_valid && !rsp_trans_valid, trans_all_one)

endmodule

bind emission_absorption_ray_march_core emission_absorption_ray_march_core_checker u_checker (.*);

>>> verif/emission_absorption_ray_march_core_tb.sv
// ----------------------------------------------------------------------------
// Emission-absorption ray march core testbench
// Drives march samples through the valid/ready request port, composites the
// same rays in a local fixed-point predictor and checks every color and
// transparency item field by field. Register settings change between phases
// while the core is drained; both sides stall at random in three regimes.
// ----------------------------------------------------------------------------
module emission_absorption_ray_march_core_tb;

   localparam int RUN_LIMIT     = 400000;  // cycles
   localparam int SETTLE_CYCLES = 40;      // longer than one last-sample pass
   localparam int RAYS_PHASE    = 108;     // at least this many sample items per random phase

   // Q1.16 one, Q2.30 log2(e), Q0.32 ln(2)
   localparam logic [16:0] T_ONE      = 17'd65536;
   localparam logic [63:0] LOG2E_FIX  = 64'd1549082005;
   localparam logic [63:0] LN2_FIX    = 64'd2977044472;
   localparam int          LUT_SIZE   = 256;
   localparam int          TAYLOR_LEN = 14;

   // channel 0 red, 1 green, 2 blue
   typedef struct packed {
      logic [2:0][31:0] absorb;
      logic [2:0][31:0] emit;
      logic             last;
   } march_sample_type;

   typedef struct packed {
      logic [2:0][31:0] color;
      logic [2:0][16:0] trans;
      logic             lit;
   } pixel_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_absorb_red = '0;
   logic signed [31:0] req_absorb_green = '0;
   logic signed [31:0] req_absorb_blue = '0;
   logic signed [31:0] req_emit_red = '0;
   logic signed [31:0] req_emit_green = '0;
   logic signed [31:0] req_emit_blue = '0;
   logic               req_last_sample = 1'b0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [31:0]        rsp_color_red;
   logic [31:0]        rsp_color_green;
   logic [31:0]        rsp_color_blue;
   logic [16:0]        rsp_trans_red;
   logic [16:0]        rsp_trans_green;
   logic [16:0]        rsp_trans_blue;
   logic               rsp_trans_valid;

   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_write_data = '0;

   // predictor state: register copies, per-channel ray state, exp(-t) table
   logic [31:0]        cfg_step   = 32'h0001_0000;
   logic [31:0]        cfg_gain   = 32'h0001_0000;
   logic [31:0]        cfg_offset = 32'h0000_0000;
   logic [16:0]        ray_trans [3];
   logic [31:0]        ray_sum [3];
   logic [16:0]        decay_lut [LUT_SIZE];

   march_sample_type   sample_queue [$];
   march_sample_type   on_bus;
   pixel_type          expected_pixels [$];
   pixel_type          oldest_pixel;
   int                 accepted_count = 0;
   int                 mismatches = 0;
   int                 cycle_count = 0;

   emission_absorption_ray_march_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall regimes by progress: sender idles 24% / receiver 69%, then the
   // reverse, then neither side idles.
   function automatic int idle_pct(input bit sender);
      if (accepted_count < 240) begin
         return sender ? 24 : 69;
      end else if (accepted_count < 480) begin
         return sender ? 69 : 24;
      end
      return 0;
   endfunction

   // exp(-t), t = k*ln2/LUT_SIZE, alternating series in Q0.32, rounded to Q1.16
   function automatic logic [16:0] decay_entry(input int unsigned k);
      logic [63:0] t;
      logic [63:0] acc;
      logic [63:0] term;
      t    = (64'(k) * LN2_FIX) / 64'(LUT_SIZE);
      acc  = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int n = 1; n <= TAYLOR_LEN; n++) begin
         term = ((term * t) >> 32) / 64'(n);
         if (n % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      return 17'((acc + 64'd32768) >> 16);
   endfunction

   // e = 2^(-depth*log2e): table on the fraction, shift on the whole part;
   // depth of 16.0 or more, or a shift past 16, gives zero
   function automatic logic [16:0] decay_factor(input logic [63:0] depth);
      logic [63:0] x;
      logic [63:0] whole;
      logic [63:0] idx;
      if (depth >= 64'h0010_0000) begin
         return '0;
      end
      x     = (depth * LOG2E_FIX) >> 30;
      whole = x >> 16;
      if (whole > 64'd16) begin
         return '0;
      end
      idx = ((x & 64'hFFFF) * 64'(LUT_SIZE)) >> 16;
      return decay_lut[idx[7:0]] >> whole;
   endfunction

   // One accepted sample: march all three channels; on the last sample form
   // the pixel and restart the ray.
   task automatic composite_sample(input march_sample_type s);
      logic [63:0]        depth;
      logic [63:0]        e;
      logic [63:0]        t;
      logic [63:0]        c;
      logic [63:0]        acc;
      logic signed [63:0] tr;
      logic signed [63:0] off;
      pixel_type          px;
      for (int ch = 0; ch < 3; ch++) begin
         depth = '0;
         // only positive absorption attenuates
         if (!s.absorb[ch][31] && s.absorb[ch] != '0) begin
            depth = (64'(s.absorb[ch]) * 64'(cfg_step)) >> 16;
         end
         e = 64'(decay_factor(depth));
         t = 64'(ray_trans[ch]);
         // only positive emission contributes; the sum saturates
         if (!s.emit[ch][31] && s.emit[ch] != '0) begin
            c   = (64'(s.emit[ch]) * t) >> 16;
            c   = (c * (64'd65536 - e)) >> 16;
            acc = 64'(ray_sum[ch]) + c;
            ray_sum[ch] = (acc > 64'hFFFF_FFFF) ? '1 : acc[31:0];
         end
         ray_trans[ch] = 17'((t * e) >> 16);
      end
      if (s.last) begin
         px.lit = 1'b0;
         for (int ch = 0; ch < 3; ch++) begin
            if (ray_trans[ch] != T_ONE) begin
               px.lit = 1'b1;
            end
         end
         off = {{32{cfg_offset[31]}}, cfg_offset};
         for (int ch = 0; ch < 3; ch++) begin
            c = (64'(ray_sum[ch]) * 64'(cfg_gain)) >> 16;
            px.color[ch] = (c > 64'hFFFF_FFFF) ? '1 : c[31:0];
            // untouched ray stays fully transparent, offset unused
            tr = 64'sd65536;
            if (px.lit) begin
               tr = $signed({47'd0, ray_trans[ch]}) + off;
               if (tr < 64'sd1) begin
                  tr = 64'sd1;
               end
               if (tr > 64'sd65536) begin
                  tr = 64'sd65536;
               end
            end
            px.trans[ch]  = tr[16:0];
            ray_trans[ch] = T_ONE;
            ray_sum[ch]   = '0;
         end
         expected_pixels.push_back(px);
      end
   endtask

   // Request driver: predict on acceptance, then load the next queued item
   // or idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            composite_sample(on_bus);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (sample_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
               on_bus = sample_queue.pop_front();
               req_absorb_red   <= on_bus.absorb[0];
               req_absorb_green <= on_bus.absorb[1];
               req_absorb_blue  <= on_bus.absorb[2];
               req_emit_red     <= on_bus.emit[0];
               req_emit_green   <= on_bus.emit[1];
               req_emit_blue    <= on_bus.emit[2];
               req_last_sample  <= on_bus.last;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   // Result monitor: compare each accepted item with the oldest pixel waiting.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("result item with no pixel expected");
               mismatches++;
            end else begin
               oldest_pixel = expected_pixels.pop_front();
               check_field("color_red", oldest_pixel.color[0], rsp_color_red);
               check_field("color_green", oldest_pixel.color[1], rsp_color_green);
               check_field("color_blue", oldest_pixel.color[2], rsp_color_blue);
               check_field("trans_red", 32'(oldest_pixel.trans[0]), 32'(rsp_trans_red));
               check_field("trans_green", 32'(oldest_pixel.trans[1]),
                           32'(rsp_trans_green));
               check_field("trans_blue", 32'(oldest_pixel.trans[2]), 32'(rsp_trans_blue));
               check_field("trans_valid", 32'(oldest_pixel.lit), 32'(rsp_trans_valid));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic push_item(input logic [31:0] a_r, input logic [31:0] a_g,
                            input logic [31:0] a_b, input logic [31:0] e_r,
                            input logic [31:0] e_g, input logic [31:0] e_b,
                            input logic last);
      march_sample_type s;
      s.absorb = {a_b, a_g, a_r};
      s.emit   = {e_b, e_g, e_r};
      s.last   = last;
      sample_queue.push_back(s);
   endtask

   // Mostly well-formed content: small and mid absorption so T decays over
   // several samples, with negatives, zeros and full-range words mixed in.
   function automatic march_sample_type shaped_sample(input bit last);
      march_sample_type s;
      for (int ch = 0; ch < 3; ch++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: s.absorb[ch] = $urandom_range(0, 32'h0004_0000);
            4, 5:       s.absorb[ch] = $urandom_range(0, 32'h0010_0000);
            6:          s.absorb[ch] = {1'b1, 31'($urandom)};
            7:          s.absorb[ch] = '0;
            default:    s.absorb[ch] = $urandom;
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: s.emit[ch] = $urandom_range(1, 32'h0100_0000);
            6, 7:             s.emit[ch] = $urandom;
            8:                s.emit[ch] = '0;
            default:          s.emit[ch] = {1'b1, 31'($urandom)};
         endcase
      end
      s.last = last;
      return s;
   endfunction

   task automatic queue_random_rays(input int count);
      int               queued;
      int               len;
      march_sample_type s;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: any word, any flag, may cut a ray short
            s.absorb = {$urandom, $urandom, $urandom};
            s.emit   = {$urandom, $urandom, $urandom};
            s.last   = 1'($urandom_range(0, 1));
            sample_queue.push_back(s);
            queued++;
         end else begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               sample_queue.push_back(shaped_sample(i == len - 1));
            end
            queued += len;
         end
      end
      // close any open ray so the phase drains completely
      sample_queue.push_back(shaped_sample(1'b1));
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         earm_pkg::CSR_STEP_LENGTH:         cfg_step = value;
         earm_pkg::CSR_DENSITY_GAIN:        cfg_gain = value;
         earm_pkg::CSR_TRANSPARENCY_OFFSET: cfg_offset = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [31:0] step, input logic [31:0] gain,
                             input logic [31:0] offset);
      write_csr(earm_pkg::CSR_STEP_LENGTH, step);
      write_csr(earm_pkg::CSR_DENSITY_GAIN, gain);
      write_csr(earm_pkg::CSR_TRANSPARENCY_OFFSET, offset);
   endtask

   // Wait for every item sent and every pixel returned, then let the
   // sequencer finish whatever trailing work it may still hold.
   task automatic drain;
      do begin
         @(negedge clock);
      end while (sample_queue.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      foreach (decay_lut[k]) begin
         decay_lut[k] = decay_entry(k);
      end
      foreach (ray_trans[ch]) begin
         ray_trans[ch] = T_ONE;
         ray_sum[ch]   = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed, register defaults after reset.
      // untouched ray: zero and negative absorption, offset unused
      push_item(32'h0, 32'hFFFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h0001_0000, 32'h0, 1'b1);
      // non-positive emission adds nothing, then extreme emission
      push_item(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
      push_item(32'h0000_8000, 32'h0000_4000, 32'h0000_0001,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      // opaque sample: T goes to zero, transparency floors at one LSB
      push_item(32'h7FFF_FFFF, 32'h0010_0000, 32'h000F_FFFF,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
      // around the shift limit of the exponential
      push_item(32'h000B_0000, 32'h000B_1800, 32'h000C_0000,
                32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
      push_item(32'h000F_FFFF, 32'h0010_0000, 32'h0000_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      // long thin ray with full red and blue emission
      for (int i = 0; i < 6; i++) begin
         push_item(32'h0000_2000, 32'h0000_1000, 32'h0000_4000,
                   32'h7FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF, i == 5);
      end
      drain();

      // Directed: full gain saturates color, negative offset hits the floor
      set_config(32'h0002_0000, 32'hFFFF_FFFF, 32'hFFFF_FE00);
      push_item(32'h0000_1000, 32'h0000_0800, 32'h0000_2000,
                32'h7FFF_FFFF, 32'h0000_0100, 32'h7FFF_FFFF, 1'b1);
      push_item(32'h7FFF_FFFF, 32'h0000_0400, 32'h0,
                32'h0100_0000, 32'h0100_0000, 32'h0, 1'b1);
      push_item(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'h1, 1'b1);
      drain();

      // Directed: zero step length, every sample transparent and dark
      set_config(32'h0, 32'h0001_0000, 32'h0000_1000);
      push_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      push_item(32'h0001_0000, 32'h0004_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 1'b1);
      drain();

      // Random phases, register extremes among them
      set_config(32'h0001_0000, 32'h0001_0000, 32'h0);
      queue_random_rays(RAYS_PHASE);
      drain();
      set_config(32'h1, 32'h0, 32'h7FFF_FFFF);
      queue_random_rays(RAYS_PHASE);
      drain();
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
      queue_random_rays(RAYS_PHASE);
      drain();
      set_config(32'h0000_4000, 32'h0002_0000, 32'hFFFF_FC18);
      queue_random_rays(RAYS_PHASE);
      drain();
      for (int i = 0; i < 2; i++) begin
         set_config($urandom_range(1, 32'h0004_0000), $urandom, $urandom);
         queue_random_rays(RAYS_PHASE);
         drain();
      end

      if (expected_pixels.size() != 0) begin
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/earm_pkg.sv
hdl/emission_absorption_ray_march_core.sv
hdl/emission_absorption_ray_march_core_checker.sv
verif/emission_absorption_ray_march_core_tb.sv
